>>> src/mcmc_pkg.sv
// Package for the substitution key search block.
// Holds the payload structs and the item kind codes; no dependencies.
package mcmc_pkg;

    localparam logic [2:0] KIND_LOAD_CIPHER = 3'd0;
    localparam logic [2:0] KIND_LOAD_TABLE  = 3'd1;
    localparam logic [2:0] KIND_LOAD_KEY    = 3'd2;
    localparam logic [2:0] KIND_SCORE       = 3'd3;
    localparam logic [2:0] KIND_PROPOSE     = 3'd4;

    typedef struct packed {
        logic [2:0]         kind;
        logic [5:0]         cipher_symbol;
        logic               is_last_symbol;
        logic [5:0]         table_row;
        logic [5:0]         table_col;
        logic signed [23:0] log_entry;
        logic [4:0]         key_slot;
        logic [5:0]         key_symbol;
        logic [4:0]         swap_first;
        logic [4:0]         swap_second;
        logic signed [23:0] log_uniform;
    } in_item_t;

    typedef struct packed {
        logic               accepted;
        logic signed [39:0] current_score;
        logic signed [39:0] best_score;
    } out_item_t;

endpackage

>>> src/mcmc_substitution_key_search.sv
// Metropolis key search for a substitution cipher under a bigram model.
// Top level; depends on mcmc_pkg. Ciphertext and bigram table sit in
// synchronous memories, the key in a small register file.
//
// Load items are taken whenever the block is idle. A score or propose item
// streams the stored text once through the cipher and table memories, one
// symbol and one table read per cycle. After the walk comes a tail step when
// the text ends on a letter, then a final step that registers the result and
// returns to idle, where the next item can be taken. If the previous result
// still waits for its transfer, the last step waits with it.
// The result waits in an output register; load items are still taken then.
module mcmc_substitution_key_search #(
    parameter int MAX_TEXT = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mcmc_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mcmc_pkg::out_item_t m_data
);
    import mcmc_pkg::*;

    localparam int ALPHA = 32;
    localparam int NCOLS = ALPHA + 1;
    localparam int TSIZE = (ALPHA + 2) * NCOLS;
    localparam int AW = $clog2(MAX_TEXT);
    localparam int LW = $clog2(MAX_TEXT + 1);
    localparam int TW = $clog2(TSIZE);
    localparam logic signed [39:0] SMAX = {1'b0, {39{1'b1}}};
    localparam logic signed [39:0] SMIN = {1'b1, {39{1'b0}}};

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_TAIL = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [5:0]         cipher_mem [MAX_TEXT];
    logic signed [23:0] table_mem  [TSIZE];
    logic [5:0]         key_reg    [ALPHA];

    logic [1:0]         state_reg;
    logic [LW-1:0]      len_reg, idx_reg;
    logic               done_reg;
    logic               prop_reg, rd_vld_reg, tb_vld_reg;
    logic [4:0]         sa_reg, sb_reg;
    logic signed [23:0] lu_reg;
    logic [5:0]         prev_reg;
    logic [5:0]         sym_q;
    logic signed [23:0] tab_q;
    logic signed [39:0] acc_reg, cur_reg, best_reg;
    logic               mv_reg;
    out_item_t          md_reg;

    logic accept_in;
    assign s_ready = (state_reg == ST_IDLE) && !(mv_reg && !m_ready &&
                     (s_data.kind == KIND_SCORE || s_data.kind == KIND_PROPOSE));
    assign accept_in = s_valid && s_ready;
    assign m_valid = mv_reg;
    assign m_data  = md_reg;

    // Decode one cipher symbol through the trial key (swap applied on the fly).
    function automatic logic [5:0] col_of(input logic [5:0] sym, input logic p,
                                         input logic [4:0] a, input logic [4:0] b,
                                         input logic [5:0] ka, input logic [5:0] kb,
                                         input logic [5:0] kk);
        logic [4:0] s;
        logic [5:0] k;
        s = 5'(sym - 6'd1);
        if (sym < 6'd1 || sym > 6'(ALPHA)) return 6'(ALPHA);
        k = kk;
        if (p && s == a) k = kb;
        else if (p && s == b) k = ka;
        if (k < 6'd1 || k > 6'(ALPHA)) return 6'(ALPHA);
        return 6'(k - 6'd1);
    endfunction

    function automatic logic signed [39:0] sat_add(input logic signed [39:0] x,
                                                   input logic signed [23:0] y);
        logic signed [40:0] s;
        s = 41'(x) + 41'(y);
        if (s > 41'(SMAX)) return SMAX;
        if (s < 41'(SMIN)) return SMIN;
        return s[39:0];
    endfunction

    logic [5:0]    col;
    logic [TW-1:0] taddr;
    assign col = col_of(sym_q, prop_reg, sa_reg, sb_reg, key_reg[sa_reg],
                        key_reg[sb_reg], key_reg[5'(sym_q - 6'd1)]);
    always_comb begin
        if (state_reg == ST_TAIL)
            taddr = TW'(prev_reg * NCOLS + ALPHA);
        else
            taddr = TW'(prev_reg * NCOLS + col);
    end

    logic [LW-1:0] ldlen;
    assign ldlen = done_reg ? '0 : len_reg;

    // Cipher memory: one write port for loads, one read port for the walk.
    always_ff @(posedge aclk) begin
        if (accept_in && s_data.kind == KIND_LOAD_CIPHER && ldlen < LW'(MAX_TEXT))
            cipher_mem[ldlen[AW-1:0]] <= s_data.cipher_symbol;
        sym_q <= cipher_mem[idx_reg[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (accept_in && s_data.kind == KIND_LOAD_TABLE &&
            s_data.table_row < 6'(ALPHA + 2) && s_data.table_col < 6'(NCOLS))
            table_mem[TW'(s_data.table_row * NCOLS + s_data.table_col)] <= s_data.log_entry;
        tab_q <= table_mem[taddr];
    end

    logic signed [39:0] fin;
    logic               acc_ok;
    logic signed [40:0] diff;
    assign fin = acc_reg;
    assign diff = 41'(fin) - 41'(cur_reg);
    assign acc_ok = !prop_reg || (41'(lu_reg) < diff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            len_reg <= '0;
            done_reg <= 1'b0;
            cur_reg <= '0;
            best_reg <= '0;
            mv_reg <= 1'b0;
            rd_vld_reg <= 1'b0;
            tb_vld_reg <= 1'b0;
        end else begin
            if (mv_reg && m_ready && state_reg != ST_DONE) mv_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept_in) begin
                        priority case (s_data.kind)
                            KIND_LOAD_CIPHER: begin
                                len_reg <= (ldlen < LW'(MAX_TEXT)) ? LW'(ldlen + 1'b1) : ldlen;
                                done_reg <= s_data.is_last_symbol;
                            end
                            KIND_LOAD_KEY: key_reg[s_data.key_slot] <= s_data.key_symbol;
                            KIND_SCORE, KIND_PROPOSE: begin
                                prop_reg <= (s_data.kind == KIND_PROPOSE);
                                sa_reg <= s_data.swap_first;
                                sb_reg <= s_data.swap_second;
                                lu_reg <= s_data.log_uniform;
                                idx_reg <= '0;
                                prev_reg <= 6'(ALPHA + 1);
                                acc_reg <= '0;
                                rd_vld_reg <= 1'b0;
                                tb_vld_reg <= 1'b0;
                                state_reg <= ST_WALK;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_WALK: begin
                    // Pipeline: cipher read, then table read, then accumulate,
                    // with a new symbol entering every cycle.
                    if (tb_vld_reg) acc_reg <= sat_add(acc_reg, tab_q);
                    if (rd_vld_reg) prev_reg <= col;
                    tb_vld_reg <= rd_vld_reg;
                    if (idx_reg < len_reg) begin
                        idx_reg <= LW'(idx_reg + 1'b1);
                        rd_vld_reg <= 1'b1;
                    end else begin
                        rd_vld_reg <= 1'b0;
                        if (!rd_vld_reg) begin
                            if (prev_reg < 6'(ALPHA))
                                state_reg <= ST_TAIL;
                            else
                                state_reg <= ST_DONE;
                        end
                    end
                end
                ST_TAIL: begin
                    tb_vld_reg <= 1'b1;
                    prev_reg <= 6'(ALPHA + 1);
                    state_reg <= ST_WALK;
                end
                ST_DONE: begin
                    if (!mv_reg || m_ready) begin
                        if (acc_ok) begin
                            cur_reg <= fin;
                            if (!prop_reg || fin > best_reg) best_reg <= fin;
                            if (prop_reg && sa_reg != sb_reg) begin
                                key_reg[sa_reg] <= key_reg[sb_reg];
                                key_reg[sb_reg] <= key_reg[sa_reg];
                            end
                        end
                        md_reg.accepted <= acc_ok;
                        md_reg.current_score <= acc_ok ? fin : cur_reg;
                        md_reg.best_score <= !acc_ok ? best_reg :
                                             (!prop_reg || fin > best_reg) ? fin : best_reg;
                        mv_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // The walk never runs past the stored text.
    a_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK |-> idx_reg <= len_reg) else $error("walk index past text");
    // A result is never overwritten before its transfer.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result lost");
    // Input is taken only when idle.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE) else $error("input taken while busy");

endmodule

>>> verif/mcmc_key_search_checker.sv
// Checker for the substitution key search block: watches both channels,
// predicts each result from its own copy of the block state and compares.
// Depends on mcmc_pkg for the payload structs and the kind codes.
`timescale 1ns / 100ps

module mcmc_key_search_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  mcmc_pkg::in_item_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  mcmc_pkg::out_item_t m_data,
    output int                  fail_count,
    output int                  pending,
    output int                  items_seen,
    output int                  results_seen,
    output int                  accepts_seen
);
    import mcmc_pkg::*;

    localparam int TEXT_DEPTH = 1024;
    localparam int LETTERS    = 32;
    localparam int SPACE_COL  = 32;
    localparam int START_ROW  = 33;
    localparam longint SCORE_TOP = (64'sd1 <<< 39) - 1;
    localparam longint SCORE_BOT = -(64'sd1 <<< 39);

    typedef logic [5:0] key_map_t [LETTERS];

    logic [5:0]         cipher_text [TEXT_DEPTH];
    int                 text_len;
    bit                 text_closed;
    key_map_t           key_map;
    logic signed [23:0] bigram_log [34][33];
    longint             cur_total;
    longint             best_total;
    out_item_t          score_queue [$];

    assign pending = score_queue.size();

    function automatic longint clamp_score(input longint s);
        if (s > SCORE_TOP) return SCORE_TOP;
        if (s < SCORE_BOT) return SCORE_BOT;
        return s;
    endfunction

    function automatic int plain_column(input key_map_t k, input logic [5:0] sym);
        int m;
        if (sym < 1 || sym > LETTERS) return SPACE_COL;
        m = k[sym - 1];
        if (m < 1 || m > LETTERS) return SPACE_COL;
        return m - 1;
    endfunction

    function automatic longint text_log_likelihood(input key_map_t k);
        longint total;
        int prev;
        int c;
        total = 0;
        prev = START_ROW;
        for (int i = 0; i < text_len; i++) begin
            c = plain_column(k, cipher_text[i]);
            total = clamp_score(total + longint'(bigram_log[prev][c]));
            prev = c;
        end
        if (prev < LETTERS) total = clamp_score(total + longint'(bigram_log[prev][SPACE_COL]));
        return total;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic predict_item(input in_item_t it);
        key_map_t trial;
        longint fresh;
        bit took;
        logic [4:0] t;
        out_item_t r;
        case (it.kind)
            KIND_LOAD_CIPHER: begin
                if (text_closed) begin
                    text_len = 0;
                    text_closed = 0;
                end
                if (text_len < TEXT_DEPTH) begin
                    cipher_text[text_len] = it.cipher_symbol;
                    text_len++;
                end
                if (it.is_last_symbol) text_closed = 1;
            end
            KIND_LOAD_TABLE: begin
                if (it.table_row < 34 && it.table_col < 33)
                    bigram_log[it.table_row][it.table_col] = it.log_entry;
            end
            KIND_LOAD_KEY: key_map[it.key_slot] = it.key_symbol;
            KIND_SCORE: begin
                cur_total = text_log_likelihood(key_map);
                best_total = cur_total;
                r.accepted = 1'b1;
                r.current_score = cur_total[39:0];
                r.best_score = best_total[39:0];
                score_queue.push_back(r);
            end
            KIND_PROPOSE: begin
                trial = key_map;
                trial[it.swap_first] = key_map[it.swap_second];
                trial[it.swap_second] = key_map[it.swap_first];
                fresh = text_log_likelihood(trial);
                took = longint'(it.log_uniform) < fresh - cur_total;
                if (took) begin
                    key_map = trial;
                    cur_total = fresh;
                    if (fresh > best_total) best_total = fresh;
                end
                r.accepted = took;
                r.current_score = cur_total[39:0];
                r.best_score = best_total[39:0];
                score_queue.push_back(r);
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            text_len <= 0;
            text_closed <= 0;
            cur_total <= 0;
            best_total <= 0;
            score_queue.delete();
            fail_count <= 0;
            items_seen <= 0;
            results_seen <= 0;
            accepts_seen <= 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_data.accepted) accepts_seen++;
                if (score_queue.size() == 0) begin
                    report("unexpected result transfer, accepted", m_data.accepted, -1);
                end else begin
                    want = score_queue.pop_front();
                    if (m_data.accepted !== want.accepted)
                        report("accepted", m_data.accepted, want.accepted);
                    if (m_data.current_score !== want.current_score)
                        report("current_score", m_data.current_score, want.current_score);
                    if (m_data.best_score !== want.best_score)
                        report("best_score", m_data.best_score, want.best_score);
                end
            end
            if (s_valid && s_ready) begin
                items_seen++;
                predict_item(s_data);
            end
        end
    end

endmodule

>>> verif/mcmc_substitution_key_search_tb.sv
// Testbench top for the substitution key search block: drives items with
// random gaps and stalls, and gives the verdict from mcmc_key_search_checker.
// Depends on mcmc_pkg, the block and the checker.
`timescale 1ns / 100ps

module mcmc_substitution_key_search_tb;
    import mcmc_pkg::*;

    localparam logic signed [23:0] LOG_FLOOR = 24'sh800000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;
    int        fail_count;
    int        pending;
    int        items_seen;
    int        results_seen;
    int        accepts_seen;
    bit        no_gaps;
    bit        stim_done;

    mcmc_substitution_key_search u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    mcmc_key_search_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending), .items_seen(items_seen),
        .results_seen(results_seen), .accepts_seen(accepts_seen)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    initial begin
        #5ms;
        $display("timeout");
        $display("mcmc_substitution_key_search: mismatch");
        $finish;
    end

    // Result side: a random stall before each transfer, none in gap-free stretches.
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(negedge aclk);
            stall = no_gaps ? 0 : $urandom_range(0, 15);
            repeat (stall) begin
                m_ready = 1'b0;
                @(negedge aclk);
            end
            m_ready = 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send(input in_item_t it, input bit hurry = 0);
        int gap;
        gap = (no_gaps || hurry) ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data = it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic in_item_t noise_item(input logic [2:0] k);
        in_item_t   it;
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        it = raw[$bits(in_item_t)-1:0];
        it.kind = k;
        return it;
    endfunction

    function automatic logic signed [23:0] pick_log();
        case ($urandom_range(0, 5))
            0: return 24'sd0;
            1: return LOG_FLOOR;
            2: return -$signed({1'b0, 23'($urandom)});
            default: return -$signed(24'($urandom_range(0, 20 * 65536)));
        endcase
    endfunction

    // Keys hold only a few plaintext symbols: both ends of the letters and a
    // non-letter, so that a small part of the table covers every lookup.
    function automatic int pick_plain();
        case ($urandom_range(0, 5))
            0: return 1;
            1: return 2;
            2: return 17;
            3: return 31;
            4: return 32;
            default: return 33;
        endcase
    endfunction

    // Table columns reachable through such keys, and the rows that precede them.
    function automatic int used_col(input int i);
        case (i)
            0: return 0;
            1: return 1;
            2: return 16;
            3: return 30;
            4: return 31;
            default: return 32;
        endcase
    endfunction

    function automatic int used_row(input int i);
        return (i < 6) ? used_col(i) : 33;
    endfunction

    task automatic put_table(input int r, input int c, input logic signed [23:0] v,
                             input bit hurry = 0);
        in_item_t it;
        it = noise_item(KIND_LOAD_TABLE);
        it.table_row = 6'(r);
        it.table_col = 6'(c);
        it.log_entry = v;
        send(it, hurry);
    endtask

    task automatic put_key(input int slot, input int sym);
        in_item_t it;
        it = noise_item(KIND_LOAD_KEY);
        it.key_slot = 5'(slot);
        it.key_symbol = 6'(sym);
        send(it);
    endtask

    // Loads a text; letter_end 1 or 0 forces the last symbol to be a letter or not, 2 leaves it random.
    task automatic put_text(input int len, input int letter_end);
        in_item_t it;
        for (int i = 0; i < len; i++) begin
            it = noise_item(KIND_LOAD_CIPHER);
            it.cipher_symbol = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(33, 63))
                                                           : 6'($urandom_range(1, 32));
            if (i == len - 1 && letter_end == 1) it.cipher_symbol = 6'($urandom_range(1, 32));
            if (i == len - 1 && letter_end == 0) it.cipher_symbol = 6'($urandom_range(33, 63));
            it.is_last_symbol = (i == len - 1);
            send(it, len > 64);
        end
    endtask

    task automatic propose(input int a, input int b, input logic signed [23:0] lu);
        in_item_t it;
        it = noise_item(KIND_PROPOSE);
        it.swap_first = 5'(a);
        it.swap_second = 5'(b);
        it.log_uniform = lu;
        send(it);
    endtask

    initial begin
        int pick;
        int wait_cycles;
        s_valid = 1'b0;
        s_data = '0;
        no_gaps = 0;
        stim_done = 0;
        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Empty text scores zero before anything is loaded.
        send(noise_item(KIND_SCORE));
        for (int k = 5; k < 8; k++) send(noise_item(3'(k)));
        // Out-of-range table coordinates are ignored.
        put_table(34, 0, -24'sd5);
        put_table(0, 33, -24'sd5);
        put_table(63, 63, -24'sd5);

        // Every table entry that the keys can reach, with extremes at the start row.
        for (int r = 0; r < 7; r++)
            for (int c = 0; c < 6; c++)
                put_table(used_row(r), used_col(c), pick_log(), 1);
        put_table(33, 0, LOG_FLOOR);
        put_table(33, 1, 24'sd0);
        for (int s = 0; s < 32; s++) put_key(s, pick_plain());

        put_text(12, 1);
        send(noise_item(KIND_SCORE));
        propose(4, 4, 24'sd0);
        propose(0, 31, LOG_FLOOR);
        propose(3, 9, 24'sd0);
        put_text(9, 0);
        send(noise_item(KIND_SCORE));
        propose(1, 2, pick_log());
        put_text(40, 1);
        send(noise_item(KIND_SCORE));
        propose(5, 6, LOG_FLOOR);
        put_text(6, 1);
        send(noise_item(KIND_SCORE));

        for (int n = 0; n < 260; n++) begin
            if ($urandom_range(0, 39) == 0) no_gaps = !no_gaps;
            pick = $urandom_range(0, 99);
            if (pick < 45) propose($urandom_range(0, 31), $urandom_range(0, 31), pick_log());
            else if (pick < 57) send(noise_item(KIND_SCORE));
            else if (pick < 71) put_key($urandom_range(0, 31), pick_plain());
            else if (pick < 85) put_table($urandom_range(0, 33), $urandom_range(0, 32), pick_log());
            else if (pick < 88) put_table($urandom_range(34, 63), $urandom_range(0, 63), pick_log());
            else if (pick < 92) send(noise_item(3'($urandom_range(5, 7))));
            else put_text($urandom_range(1, 16), $urandom_range(0, 2));
        end
        s_valid = 1'b0;
        stim_done = 1;

        while (pending != 0) @(posedge aclk);
        wait_cycles = 1100;
        repeat (wait_cycles) @(posedge aclk);
        $display("Covered %0d input transfers and %0d result transfers (%0d accepted),",
                 items_seen, results_seen, accepts_seen);
        $display("including empty texts, texts ending on letters and on other symbols.");
        if (fail_count == 0) begin
            $display("mcmc_substitution_key_search: match");
        end else begin
            $display("mcmc_substitution_key_search: mismatch");
        end
        $finish;
    end

endmodule
